// File: rtl/fcpwm_pkg.sv
// Shared types and constants of the linear fan-curve PWM controller.
package fcpwm_pkg;

  localparam int unsigned FAN_IDX_W  = 4;
  localparam int unsigned TEMP_W     = 16;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned DUTY_W     = 17;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned FANS_W     = 4;

  // Interpolation numerator and divider sizing.
  localparam int unsigned PROD_W     = DUTY_W + TEMP_W;
  localparam int unsigned DIV_CNT_W  = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 5'd17;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FANS_IN_USE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_TEMP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_DUTY    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_TEMP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_DUTY   = 3'd4;

  // Reset values; the duty resets to twenty percent.
  localparam logic [FANS_W-1:0]        RST_FANS_IN_USE = 4'd8;
  localparam logic signed [TEMP_W-1:0] RST_LOW_TEMP    = 16'sd7680;
  localparam logic [DUTY_W-1:0]        RST_LOW_DUTY    = 17'd13107;
  localparam logic signed [TEMP_W-1:0] RST_HIGH_TEMP   = 16'sd17920;
  localparam logic [DUTY_W-1:0]        RST_HIGH_DUTY   = 17'd65536;
  localparam logic [DUTY_W-1:0]        RST_DUTY        = 17'd13107;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_SET     = 2'd1,
    OP_COMPUTE = 2'd2
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CURVE,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV,
    ST_EMIT_RD,
    ST_EMIT_MUL,
    ST_EMIT_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]                operation;
    logic [FAN_IDX_W-1:0]      fan_index;
    logic signed [TEMP_W-1:0]  temperature;
    logic [COUNT_W-1:0]        max_count;
  } in_word_t;

  typedef struct packed {
    logic                 status;
    logic [FAN_IDX_W-1:0] out_index;
    logic [COUNT_W-1:0]   pwm_count;
    logic [DUTY_W-1:0]    duty;
    logic                 last;
  } out_word_t;

endpackage

// File: rtl/fcpwm_in_if.sv
// Input channel of the fan-curve controller: valid, ready and one command word.
interface fcpwm_in_if;
  import fcpwm_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/fcpwm_out_if.sv
// Result channel of the fan-curve controller: valid, ready and one result word.
interface fcpwm_out_if;
  import fcpwm_pkg::*;

  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/fcpwm_div.sv
// Restoring divider that produces one quotient bit of the curve interpolation per cycle.
module fcpwm_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [fcpwm_pkg::PROD_W-1:0]      dividend_i,
  input  logic [fcpwm_pkg::TEMP_W-1:0]      divisor_i,
  output logic                              done_o,
  output logic [fcpwm_pkg::DUTY_W-1:0]      quotient_o
);
  import fcpwm_pkg::*;

  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 done_q, done_d;
  logic [TEMP_W-1:0]    rem_q, rem_d;
  logic [DUTY_W-1:0]    lo_q, lo_d;
  logic [DUTY_W-1:0]    quo_q, quo_d;
  logic [TEMP_W:0]      trial;
  logic [TEMP_W:0]      trial_sub;
  logic                 ge;

  // The upper dividend bits are already below the divisor because the
  // quotient never exceeds the duty span, so only the low bits are iterated.
  assign trial     = {rem_q, lo_q[DUTY_W-1]};
  assign trial_sub = trial - {1'b0, divisor_i};
  assign ge        = trial >= {1'b0, divisor_i};

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    lo_d   = lo_q;
    quo_d  = quo_q;
    if (start_i) begin
      cnt_d = DIV_STEPS;
      rem_d = dividend_i[PROD_W-1:DUTY_W];
      lo_d  = dividend_i[DUTY_W-1:0];
      quo_d = '0;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - DIV_CNT_W'(1);
      done_d = (cnt_q == DIV_CNT_W'(1));
      rem_d  = ge ? trial_sub[TEMP_W-1:0] : trial[TEMP_W-1:0];
      lo_d   = {lo_q[DUTY_W-2:0], 1'b0};
      quo_d  = {quo_q[DUTY_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    lo_q  <= lo_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: rtl/fan_curve_pwm_from_max_temperature_unit.sv
// Top level of the linear fan-curve PWM controller with its temperature and count memories.
//
// Channel   Role    Word        Moves
// in_i      sink    in_word_t   one command: load max count, set temperature or compute
// out_o     source  out_word_t  one result: status, fan index, count, duty, last flag
// cfg_*     write   17 bits     one configuration register per write, no read-back
//
// Load and set each leave one result in the output register.
// Compute runs the maximum search over the n fans in use, the curve decision, the
// multiply and the bit-serial divide (skipped when the curve clamps), and then the
// read, multiply and output of each count.
// The block takes one command at a time; a waiting result holds off the next
// command, and a stalled result stalls the compute sequence.
// Reset clears the memory valid bits, so both memories read as zero until
// written, and returns the duty to twenty percent. No clearing pass is needed.
module fan_curve_pwm_from_max_temperature_unit #(
  parameter int unsigned NUM_FANS = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  fcpwm_in_if.sink                           in_i,
  fcpwm_out_if.source                        out_o,
  input  logic                               cfg_we_i,
  input  logic [fcpwm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [fcpwm_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import fcpwm_pkg::*;

  // Address width of the memories and width of a counter that can hold NUM_FANS.
  localparam int unsigned IdxW = (NUM_FANS > 1) ? $clog2(NUM_FANS) : 1;
  localparam int unsigned CntW = $clog2(NUM_FANS + 1);
  localparam int unsigned WideW = FAN_IDX_W + 1;
  localparam logic [WideW-1:0] NumFansW = WideW'(NUM_FANS);

  // Configuration registers.
  logic [FANS_W-1:0]        fans_in_use_q;
  logic signed [TEMP_W-1:0] low_temp_q;
  logic [DUTY_W-1:0]        low_duty_q;
  logic signed [TEMP_W-1:0] high_temp_q;
  logic [DUTY_W-1:0]        high_duty_q;

  // Control state.
  state_e             state_q, state_d;
  logic [DUTY_W-1:0]  duty_q, duty_d;
  logic [CntW-1:0]    scan_idx_q, scan_idx_d;
  logic               scan_pend_q, scan_pend_d;
  logic               scan_first_q, scan_first_d;
  logic [CntW-1:0]    emit_idx_q, emit_idx_d;
  logic               out_valid_q, out_valid_d;

  // Datapath registers.
  logic signed [TEMP_W-1:0] tmax_q, tmax_d;
  logic [DUTY_W-1:0]        mag_q, mag_d;
  logic                     neg_q, neg_d;
  logic [TEMP_W-1:0]        tdiff_q, tdiff_d;
  logic [TEMP_W-1:0]        den_q, den_d;
  logic [PROD_W-1:0]        prod_q, prod_d;
  logic [PROD_W-1:0]        cnt_prod_q, cnt_prod_d;
  out_word_t                out_word_q, out_word_d;

  // Temperature memory and its per-entry valid bits.
  logic [TEMP_W-1:0]   temp_mem [NUM_FANS];
  logic [NUM_FANS-1:0] temp_vld_q;
  logic                temp_we, temp_re;
  logic [IdxW-1:0]     temp_waddr, temp_raddr;
  logic [TEMP_W-1:0]   temp_rd_q;
  logic                temp_rd_vld_q;

  // Maximum-count memory and its per-entry valid bits.
  logic [COUNT_W-1:0]  max_mem [NUM_FANS];
  logic [NUM_FANS-1:0] max_vld_q;
  logic                max_we, max_re;
  logic [IdxW-1:0]     max_waddr, max_raddr;
  logic [COUNT_W-1:0]  max_rd_q;
  logic                max_rd_vld_q;

  // Misc combinational signals.
  logic                     in_acc;
  logic                     out_free;
  logic [WideW-1:0]         fans_wide;
  logic [WideW-1:0]         fan_cnt_wide;
  logic [CntW-1:0]          fan_cnt;
  logic [WideW-1:0]         idx_wide;
  logic                     scan_issue;
  logic signed [TEMP_W-1:0] scan_val;
  logic [COUNT_W-1:0]       max_val;
  logic signed [TEMP_W:0]   tdiff_w;
  logic signed [TEMP_W:0]   den_w;
  logic signed [DUTY_W:0]   span_w;
  logic signed [DUTY_W:0]   span_abs;
  logic [DUTY_W:0]          duty_sum;
  logic                     emit_last;
  logic [WideW-1:0]         emit_wide;
  logic                     div_start;
  logic                     div_done;
  logic [DUTY_W-1:0]        div_quo;

  // The divider sits behind its own boundary: it is the only multi-cycle unit.
  fcpwm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (den_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  // Fans in use, saturated to 1..NUM_FANS.
  assign fans_wide = {1'b0, fans_in_use_q};
  always_comb begin
    if (fans_in_use_q == '0) begin
      fan_cnt_wide = WideW'(1);
    end else if (fans_wide > NumFansW) begin
      fan_cnt_wide = NumFansW;
    end else begin
      fan_cnt_wide = fans_wide;
    end
  end
  assign fan_cnt  = fan_cnt_wide[CntW-1:0];
  assign idx_wide = {1'b0, in_i.data.fan_index};

  // Entries that were never written read as zero.
  assign scan_issue = scan_idx_q < fan_cnt;
  assign scan_val   = temp_rd_vld_q ? $signed(temp_rd_q) : '0;
  assign max_val    = max_rd_vld_q ? max_rd_q : '0;

  // Curve operands; between the points both differences are positive and fit 16 bits.
  assign tdiff_w  = {tmax_q[TEMP_W-1], tmax_q} - {low_temp_q[TEMP_W-1], low_temp_q};
  assign den_w    = {high_temp_q[TEMP_W-1], high_temp_q} - {low_temp_q[TEMP_W-1], low_temp_q};
  assign span_w   = $signed({1'b0, high_duty_q}) - $signed({1'b0, low_duty_q});
  assign span_abs = span_w[DUTY_W] ? -span_w : span_w;

  // Truncation toward zero: divide the magnitude and apply the sign afterwards.
  assign duty_sum = neg_q ? ({1'b0, low_duty_q} - {1'b0, div_quo})
                          : ({1'b0, low_duty_q} + {1'b0, div_quo});

  assign emit_last = (emit_idx_q + CntW'(1)) == fan_cnt;
  assign emit_wide = WideW'(emit_idx_q);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_i.data.operation == OP_COMPUTE)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!scan_issue && !scan_pend_q) begin
          state_d = ST_CURVE;
        end
      end
      ST_CURVE: begin
        if ((tmax_q <= low_temp_q) || (tmax_q >= high_temp_q)) begin
          state_d = ST_EMIT_RD;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:    state_d = ST_DIV_GO;
      ST_DIV_GO: state_d = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD:  state_d = ST_EMIT_MUL;
      ST_EMIT_MUL: state_d = ST_EMIT_OUT;
      ST_EMIT_OUT: begin
        if (out_free) begin
          state_d = emit_last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control for each state.
  always_comb begin
    duty_d       = duty_q;
    scan_idx_d   = scan_idx_q;
    scan_pend_d  = scan_pend_q;
    scan_first_d = scan_first_q;
    emit_idx_d   = emit_idx_q;
    tmax_d       = tmax_q;
    mag_d        = mag_q;
    neg_d        = neg_q;
    tdiff_d      = tdiff_q;
    den_d        = den_q;
    prod_d       = prod_q;
    cnt_prod_d   = cnt_prod_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_word_d   = out_word_q;
    temp_we      = 1'b0;
    temp_re      = 1'b0;
    temp_waddr   = in_i.data.fan_index[IdxW-1:0];
    temp_raddr   = scan_idx_q[IdxW-1:0];
    max_we       = 1'b0;
    max_re       = 1'b0;
    max_waddr    = in_i.data.fan_index[IdxW-1:0];
    max_raddr    = emit_idx_q[IdxW-1:0];
    div_start    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          out_word_d.out_index = in_i.data.fan_index;
          out_word_d.pwm_count = '0;
          out_word_d.duty      = duty_q;
          out_word_d.last      = 1'b1;
          case (in_i.data.operation)
            OP_LOAD: begin
              max_we             = idx_wide < NumFansW;
              out_word_d.status  = max_we ? STATUS_OK : STATUS_RANGE;
              out_valid_d        = 1'b1;
            end
            OP_SET: begin
              temp_we            = idx_wide < fan_cnt_wide;
              out_word_d.status  = temp_we ? STATUS_OK : STATUS_RANGE;
              out_valid_d        = 1'b1;
            end
            OP_COMPUTE: begin
              scan_idx_d   = '0;
              scan_pend_d  = 1'b0;
              scan_first_d = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        // One read issued per cycle; the compare lags it by the read latency.
        temp_re     = scan_issue;
        scan_pend_d = scan_issue;
        if (scan_issue) begin
          scan_idx_d = scan_idx_q + CntW'(1);
        end
        if (scan_pend_q) begin
          scan_first_d = 1'b0;
          if (scan_first_q || (scan_val > tmax_q)) begin
            tmax_d = scan_val;
          end
        end
      end
      ST_CURVE: begin
        emit_idx_d = '0;
        mag_d      = span_abs[DUTY_W-1:0];
        neg_d      = span_w[DUTY_W];
        tdiff_d    = tdiff_w[TEMP_W-1:0];
        den_d      = den_w[TEMP_W-1:0];
        if (tmax_q <= low_temp_q) begin
          duty_d = low_duty_q;
        end else if (tmax_q >= high_temp_q) begin
          duty_d = high_duty_q;
        end
      end
      ST_MUL: begin
        prod_d = {{TEMP_W{1'b0}}, mag_q} * {{DUTY_W{1'b0}}, tdiff_q};
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
      end
      ST_DIV: begin
        if (div_done) begin
          duty_d = duty_sum[DUTY_W-1:0];
        end
      end
      ST_EMIT_RD: begin
        max_re = 1'b1;
      end
      ST_EMIT_MUL: begin
        cnt_prod_d = {{COUNT_W{1'b0}}, duty_q} * {{DUTY_W{1'b0}}, max_val};
      end
      ST_EMIT_OUT: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_word_d.status    = STATUS_OK;
          out_word_d.out_index = emit_wide[FAN_IDX_W-1:0];
          // A duty above one can push the count past 16 bits; it saturates.
          out_word_d.pwm_count = cnt_prod_q[PROD_W-1] ? {COUNT_W{1'b1}}
                                                      : cnt_prod_q[PROD_W-2:COUNT_W];
          out_word_d.duty      = duty_q;
          out_word_d.last      = emit_last;
          emit_idx_d           = emit_idx_q + CntW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      duty_q        <= RST_DUTY;
      scan_idx_q    <= '0;
      scan_pend_q   <= 1'b0;
      scan_first_q  <= 1'b0;
      emit_idx_q    <= '0;
      out_valid_q   <= 1'b0;
      temp_vld_q    <= '0;
      max_vld_q     <= '0;
      fans_in_use_q <= RST_FANS_IN_USE;
      low_temp_q    <= RST_LOW_TEMP;
      low_duty_q    <= RST_LOW_DUTY;
      high_temp_q   <= RST_HIGH_TEMP;
      high_duty_q   <= RST_HIGH_DUTY;
    end else begin
      state_q      <= state_d;
      duty_q       <= duty_d;
      scan_idx_q   <= scan_idx_d;
      scan_pend_q  <= scan_pend_d;
      scan_first_q <= scan_first_d;
      emit_idx_q   <= emit_idx_d;
      out_valid_q  <= out_valid_d;
      if (temp_we) begin
        temp_vld_q[temp_waddr] <= 1'b1;
      end
      if (max_we) begin
        max_vld_q[max_waddr] <= 1'b1;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FANS_IN_USE: fans_in_use_q <= cfg_data_i[FANS_W-1:0];
          REG_LOW_TEMP:    low_temp_q    <= $signed(cfg_data_i[TEMP_W-1:0]);
          REG_LOW_DUTY:    low_duty_q    <= cfg_data_i[DUTY_W-1:0];
          REG_HIGH_TEMP:   high_temp_q   <= $signed(cfg_data_i[TEMP_W-1:0]);
          REG_HIGH_DUTY:   high_duty_q   <= cfg_data_i[DUTY_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    tmax_q     <= tmax_d;
    mag_q      <= mag_d;
    neg_q      <= neg_d;
    tdiff_q    <= tdiff_d;
    den_q      <= den_d;
    prod_q     <= prod_d;
    cnt_prod_q <= cnt_prod_d;
    out_word_q <= out_word_d;
  end

  // Temperature memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (temp_we) begin
      temp_mem[temp_waddr] <= in_i.data.temperature;
    end
    if (temp_re) begin
      temp_rd_q     <= temp_mem[temp_raddr];
      temp_rd_vld_q <= temp_vld_q[temp_raddr];
    end
  end

  // Maximum-count memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (max_we) begin
      max_mem[max_waddr] <= in_i.data.max_count;
    end
    if (max_re) begin
      max_rd_q     <= max_mem[max_raddr];
      max_rd_vld_q <= max_vld_q[max_raddr];
    end
  end

  assign in_i.ready = (state_q == ST_IDLE) && !out_valid_q;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_word_q;

  // A load or set command leaves exactly one final result in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && ((in_i.data.operation == OP_LOAD) || (in_i.data.operation == OP_SET))
    |=> out_valid_q && out_word_q.last)
    else $error("load or set produced no final result");

  // The divider only finishes while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide state");

  // Counts are only produced for fans in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT_OUT |-> emit_idx_q < fan_cnt)
    else $error("emit index beyond fans in use");

  // The duty changes only when a compute resolves the curve.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(duty_q) |-> $past(state_q) == ST_CURVE || $past(state_q) == ST_DIV)
    else $error("duty changed outside a compute");

endmodule
